// ===== hw/rtl/bfer_pkg.sv =====
// Package: shared constants, codes and payload types for the broadcast FIFO.
package bfer_pkg;

  localparam int FIFO_DEPTH  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int RDR_W       = 3;
  localparam int READERS     = 1 << RDR_W;
  localparam int REG_W       = 5;

  localparam logic [REG_W-1:0] CAPACITY_RST = REG_W'(10);
  localparam logic [REG_W-1:0] XLIMIT_RST   = REG_W'(8);

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_XLIMIT   = 1'b1;

  localparam logic MODE_PUT = 1'b0;
  localparam logic MODE_GET = 1'b1;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_XLIMIT = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;

  typedef struct packed {
    logic             mode;
    logic [RDR_W-1:0] reader;
    logic [7:0]       item_value;
    logic             express;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] head_value;
    logic       head_express;
    logic       removed;
  } rsp_t;

  typedef struct packed {
    logic             is_put;
    logic             reader_ok;
    logic [RDR_W-1:0] reader;
    logic [7:0]       item_value;
    logic             express;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

endpackage

// ===== hw/rtl/broadcast_fifo_eight_readers_core.sv =====
// Top level: broadcast FIFO with eight readers, queue-style request and result ports.
// Path: an accepted request passes the command queue, the back end (IDLE, then EXEC) and
// the result queue; the back end waits while the result queue is full and takes no new
// command until the last has executed, set by the head-entry read before each update.
// Reset (rst, synchronous): empties all queues and the FIFO, clears read marks,
// capacity returns to 10 and express limit to 8; entry memory contents are kept.
module broadcast_fifo_eight_readers_core
  import bfer_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  req_t             request,
  input  logic             pop,
  output logic             empty,
  output rsp_t             result,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  cmd_t                    cmd;
  logic                    cmd_empty;
  logic                    cmd_pop;
  logic                    res_full;
  logic                    res_push;
  rsp_t                    res;
  logic [$bits(rsp_t)-1:0] res_bits;

  bfer_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .request   (request),
    .full      (full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  bfer_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  bfer_queue #(
    .WIDTH  ($bits(rsp_t)),
    .QDEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_bits),
    .empty (empty)
  );

  assign result = rsp_t'(res_bits);

endmodule

// ===== hw/rtl/bfer_queue.sv =====
// Small register queue used between the front, the back and the result port.
module bfer_queue #(
  parameter int WIDTH = 8,
  parameter int QDEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0] slots [QDEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/bfer_front.sv =====
// Front end: accepts requests, classifies them and queues commands for the back end.
module bfer_front
  import bfer_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t request,
  output logic full,
  input  logic cmd_pop,
  output cmd_t cmd,
  output logic cmd_empty
);

  cmd_t                 cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_bits;

  always_comb begin
    cmd_in.is_put     = (request.mode == MODE_PUT);
    cmd_in.reader_ok  = (int'(request.reader) < READERS);
    cmd_in.reader     = request.reader;
    cmd_in.item_value = request.item_value;
    cmd_in.express    = request.express;
  end

  bfer_queue #(
    .WIDTH  ($bits(cmd_t)),
    .QDEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .empty (cmd_empty)
  );

  assign cmd = cmd_t'(cmd_bits);

endmodule

// ===== hw/rtl/bfer_back.sv =====
// Back end: entry memory, head pointer, counts, read marks and config registers.
module bfer_back
  import bfer_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  input  cmd_t             cmd,
  input  logic             cmd_empty,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output rsp_t             res
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int CW   = (CNTW > REG_W) ? CNTW : REG_W;
  localparam int SW   = CNTW + 1;

  back_state_t      state;
  back_state_t      state_next;
  cmd_t             cur;
  logic [8:0]       entries [DEPTH];
  logic [8:0]       head_entry;
  logic [PW-1:0]    head;
  logic [CNTW-1:0]  count;
  logic [CNTW-1:0]  xcount;
  logic [READERS-1:0] marks;
  logic [REG_W-1:0] capacity;
  logic [REG_W-1:0] xlimit;

  logic [CW-1:0]      cap_eff;
  logic               put_full;
  logic               put_drop;
  logic               put_ok;
  logic               get_empty;
  logic               get_marked;
  logic               get_ok;
  logic [READERS-1:0] marks_set;
  logic               pop_head;
  logic [SW-1:0]      slot_sum;
  logic [PW-1:0]      slot;
  logic [PW-1:0]      head_inc;
  logic               exec;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!cmd_empty && !res_full) begin
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    exec     = 1'b0;
    unique case (state)
      BK_IDLE: cmd_pop = !cmd_empty && !res_full;
      BK_EXEC: begin
        res_push = 1'b1;
        exec     = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    cap_eff    = (CW'(capacity) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(capacity);
    put_full   = (CW'(count) >= cap_eff);
    put_drop   = cur.express && (CW'(xcount) >= CW'(xlimit));
    put_ok     = !put_full && !put_drop;
    get_empty  = (count == '0);
    get_marked = !cur.reader_ok || marks[cur.reader];
    get_ok     = !get_empty && !get_marked;
    marks_set  = marks | (READERS'(1) << cur.reader);
    pop_head   = get_ok && (head_entry[8] || (&marks_set));
    slot_sum   = SW'(head) + SW'(count);
    slot       = (slot_sum >= SW'(DEPTH)) ? PW'(slot_sum - SW'(DEPTH)) : PW'(slot_sum);
    head_inc   = (head == PW'(DEPTH - 1)) ? '0 : head + 1'b1;

    res = '0;
    if (cur.is_put) begin
      if (put_full) begin
        res.status = ST_FULL;
      end else if (put_drop) begin
        res.status = ST_XLIMIT;
      end else begin
        res.status = ST_OK;
      end
    end else begin
      if (get_empty) begin
        res.status = ST_EMPTY;
      end else if (get_marked) begin
        res.status = ST_READ;
      end else begin
        res.status       = ST_OK;
        res.head_value   = head_entry[7:0];
        res.head_express = head_entry[8];
        res.removed      = pop_head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec && cur.is_put && put_ok) begin
      entries[slot] <= {cur.express, cur.item_value};
    end
    head_entry <= entries[head];
    if (cmd_pop) begin
      cur <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      head     <= '0;
      count    <= '0;
      xcount   <= '0;
      marks    <= '0;
      capacity <= CAPACITY_RST;
      xlimit   <= XLIMIT_RST;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_CAPACITY: capacity <= cfg_data;
          CFG_XLIMIT:   xlimit   <= cfg_data;
          default: ;
        endcase
      end
      if (exec) begin
        if (cur.is_put) begin
          if (put_ok) begin
            count <= count + 1'b1;
            if (cur.express) begin
              xcount <= xcount + 1'b1;
            end
          end
        end else if (get_ok) begin
          if (head_entry[8]) begin
            head   <= head_inc;
            count  <= count - 1'b1;
            if (xcount != '0) begin
              xcount <= xcount - 1'b1;
            end
          end else if (&marks_set) begin
            head  <= head_inc;
            count <= count - 1'b1;
            marks <= '0;
          end else begin
            marks <= marks_set;
          end
        end
      end
    end
  end

endmodule

// ===== sim/broadcast_fifo_eight_readers_core_tb.sv =====
// Testbench for the broadcast FIFO core: directed and random traffic checked against an in-bench model.
`timescale 1ns / 1ps

module broadcast_fifo_eight_readers_core_tb;
  import bfer_pkg::*;

  localparam int LIMIT = 400000;

  logic             clk;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  req_t             request = '0;
  logic             pop = 1'b0;
  logic             empty;
  rsp_t             result;
  logic             cfg_write = 1'b0;
  logic             cfg_index = CFG_CAPACITY;
  logic [REG_W-1:0] cfg_data = '0;

  broadcast_fifo_eight_readers_core dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .request(request),
    .pop(pop),
    .empty(empty),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // model state
  logic [7:0]       m_values [FIFO_DEPTH];
  logic             m_express [FIFO_DEPTH];
  logic [3:0]       m_head;
  logic [4:0]       m_count;
  logic [4:0]       m_xcount;
  logic [7:0]       m_marks;
  logic [REG_W-1:0] m_capacity;
  logic [REG_W-1:0] m_xlimit;

  req_t req_backlog[$];
  rsp_t pending_results[$];
  int   taken_cnt = 0;
  int   sent_cnt = 0;
  int   mismatches = 0;
  int   cycles = 0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   rx_cyc = 0;
  int   rx_mode = 0;
  rsp_t want;
  logic bad;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic req_t mk(logic m, logic [2:0] rd, logic [7:0] v, logic x);
    req_t r;
    r.mode = m;
    r.reader = rd;
    r.item_value = v;
    r.express = x;
    return r;
  endfunction

  function automatic void add_req(req_t r);
    req_backlog.insert(req_backlog.size(), r);
  endfunction

  function automatic rsp_t broadcast_step(req_t r);
    rsp_t       o;
    logic [4:0] eff;
    logic [3:0] slot;
    o = '0;
    if (r.mode == MODE_PUT) begin
      eff = (m_capacity > FIFO_DEPTH) ? 5'(FIFO_DEPTH) : m_capacity;
      if (m_count >= eff) begin
        o.status = ST_FULL;
      end else if (r.express && m_xcount >= m_xlimit) begin
        o.status = ST_XLIMIT;
      end else begin
        slot = m_head + m_count[3:0];
        m_values[slot] = r.item_value;
        m_express[slot] = r.express;
        m_count++;
        if (r.express) m_xcount++;
        o.status = ST_OK;
      end
    end else if (m_count == 0) begin
      o.status = ST_EMPTY;
    end else if (m_marks[r.reader]) begin
      o.status = ST_READ;
    end else begin
      o.status = ST_OK;
      o.head_value = m_values[m_head];
      o.head_express = m_express[m_head];
      if (m_express[m_head]) begin
        m_head++;
        m_count--;
        if (m_xcount > 0) m_xcount--;
        o.removed = 1'b1;
      end else begin
        m_marks[r.reader] = 1'b1;
        if (m_marks == 8'hFF) begin
          m_head++;
          m_count--;
          m_marks = '0;
          o.removed = 1'b1;
        end
      end
    end
    return o;
  endfunction

  task automatic note_error(string what, rsp_t exp_r, rsp_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected st=%0d val=%02h x=%0b rm=%0b, got st=%0d val=%02h x=%0b rm=%0b",
               $time, what, exp_r.status, exp_r.head_value, exp_r.head_express, exp_r.removed,
               got.status, got.head_value, got.head_express, got.removed);
  endtask

  task automatic write_reg(logic idx, logic [REG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == CFG_CAPACITY) m_capacity = data;
    else m_xlimit = data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_drained();
    while (req_backlog.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic gen_traffic(int n);
    int         made;
    int         k;
    int         t;
    int         j;
    logic [2:0] perm [8];
    logic [2:0] sw;
    made = 0;
    while (made < n) begin
      t = $urandom_range(0, 99);
      if (t < 40) begin
        k = $urandom_range(1, 8);
        for (int i = 0; i < k; i++)
          add_req(mk(MODE_PUT, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                     $urandom_range(0, 9) < 3));
      end else if (t < 88) begin
        for (int i = 0; i < 8; i++) perm[i] = 3'(i);
        for (int i = 7; i > 0; i--) begin
          j = $urandom_range(0, i);
          sw = perm[i];
          perm[i] = perm[j];
          perm[j] = sw;
        end
        k = (t < 82) ? 8 : $urandom_range(1, 7);
        for (int i = 0; i < k; i++)
          add_req(mk(MODE_GET, perm[i], 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1))));
      end else begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++)
          add_req(mk(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      end
      made += k;
    end
  endtask

  // sender: bursts of items separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (taken_cnt != sent_cnt) begin
        sent_cnt = taken_cnt;
        void'(req_backlog.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
          burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 20);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (req_backlog.size() > 0) begin
        push <= 1'b1;
        request <= req_backlog[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes every so often, long hold on request
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      rx_cyc++;
      if (rx_cyc % 97 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (rx_mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= (rx_cyc % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        pending_results.insert(pending_results.size(), broadcast_step(request));
        taken_cnt++;
      end
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          note_error("unexpected item", '0, result);
        end else begin
          want = pending_results.pop_front();
          bad = (result.status !== want.status) || (result.head_value !== want.head_value) ||
                (result.head_express !== want.head_express) ||
                (result.removed !== want.removed);
          if (bad) note_error("mismatch", want, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int caps [12];
    int xls [12];
    int n;
    caps = '{16, 5, 16, 0, 31, 1, 12, 8, 2, 10, 0, 0};
    xls = '{16, 2, 0, 3, 31, 1, 17, 5, 0, 8, 0, 0};
    m_head = '0;
    m_count = '0;
    m_xcount = '0;
    m_marks = '0;
    m_capacity = CAPACITY_RST;
    m_xlimit = XLIMIT_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(CFG_CAPACITY, 5'd3);
    write_reg(CFG_XLIMIT, 5'd1);
    @(posedge clk);
    add_req(mk(MODE_GET, 3'd0, 8'h00, 1'b0));
    add_req(mk(MODE_PUT, 3'd0, 8'hFF, 1'b0));
    add_req(mk(MODE_PUT, 3'd7, 8'h00, 1'b1));
    add_req(mk(MODE_PUT, 3'd0, 8'hA5, 1'b1));
    add_req(mk(MODE_PUT, 3'd0, 8'h5A, 1'b0));
    add_req(mk(MODE_PUT, 3'd0, 8'h3C, 1'b1));
    add_req(mk(MODE_GET, 3'd0, 8'hFF, 1'b1));
    add_req(mk(MODE_GET, 3'd0, 8'h00, 1'b0));
    for (int i = 1; i < 8; i++)
      add_req(mk(MODE_GET, 3'(i), 8'h00, 1'b0));
    add_req(mk(MODE_GET, 3'd3, 8'h00, 1'b0));
    add_req(mk(MODE_PUT, 3'd0, 8'h81, 1'b1));
    for (int i = 7; i >= 0; i--)
      add_req(mk(MODE_GET, 3'(i), 8'h00, 1'b0));
    wait_drained();

    caps[10] = $urandom_range(1, 16);
    xls[10] = $urandom_range(0, 16);
    caps[11] = $urandom_range(1, 16);
    xls[11] = $urandom_range(0, 16);
    for (int p = 0; p < 12; p++) begin
      write_reg(CFG_CAPACITY, REG_W'(caps[p]));
      write_reg(CFG_XLIMIT, REG_W'(xls[p]));
      @(posedge clk);
      if (p == 0 || p == 6) hold_req++;
      n = (caps[p] == 0) ? 60 : 135;
      gen_traffic(n);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
